>>> hw/rtl/gaussian_blur_3x3_rgb_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the blur unit
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_3X3_RGB_UNIT_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_RGB_UNIT_ASSERT_SVH

// implication checked every clock, quiet in reset
`define GB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gb3_pkg.sv
// ---------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 Gaussian blur unit.
// ---------------------------------------------------------------------------
`default_nettype none
package gb3_pkg;
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_CENTER = 3'd2,
    REG_EDGE   = 3'd3,
    REG_CORNER = 3'd4
  } reg_idx_t;

  typedef logic [23:0] pix_t;

  // input channel payload: one raster pixel
  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_t;

  // result channel payload: one filtered pixel
  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [15:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_burst;
  } out_t;

  // one window to filter: taps [row][col]
  typedef struct packed {
    pix_t [2:0][2:0] tap;
    logic [15:0]     row;
    logic [9:0]      col;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] row;
    logic [9:0]  col;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] center;
    logic [15:0] edge_w;
    logic [15:0] corner;
  } coef_t;
endpackage
`default_nettype wire

>>> hw/rtl/gb3_stream_if.sv
// ---------------------------------------------------------------------------
// gb3_stream_if
// Valid/ready channel carrying a generic payload.
// ---------------------------------------------------------------------------
`default_nettype none
interface gb3_stream_if #(parameter type PAYLOAD_T = logic [7:0]);
  logic     valid;
  logic     ready;
  PAYLOAD_T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/gaussian_blur_3x3_rgb_unit.sv
// An accepted pixel passes window stages A and B and the lane registers
// before its first result. Throughput: one pixel per clock unless the
// output stalls or a burst of results holds the input; one result per
// clock while not stalled (single three-lane filter pipeline). Reset:
// rst_n synchronous, clears counters and valids, sets config defaults.
// Line stores are not cleared; they are written before being read.
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_rgb_unit
// Streaming clamp-to-edge 3x3 Gaussian blur on RGB pixels.
// ---------------------------------------------------------------------------
`default_nettype none
module gaussian_blur_3x3_rgb_unit #(
  parameter int unsigned MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  gb3_stream_if.sink                               in_ch,
  gb3_stream_if.source                             out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [gb3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gb3_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gb3_pkg::*;
  `include "gaussian_blur_3x3_rgb_unit_assert.svh"

  logic [10:0] width_r;
  logic [15:0] height_r;
  coef_t       coef_r;
  logic        restart;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 16'd480;
      coef_r   <= '{center: 16'd13380, edge_w: 16'd8116, corner: 16'd4922};
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r       <= cfg_data[10:0];
        REG_HEIGHT: height_r      <= cfg_data;
        REG_CENTER: coef_r.center <= cfg_data;
        REG_EDGE:   coef_r.edge_w <= cfg_data;
        REG_CORNER: coef_r.corner <= cfg_data;
        default: ;
      endcase
    end
  end
  assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  logic  job_valid, job_ready;
  job_t  job;
  res_t  res;
  pix_t  pix;
  assign pix = {in_ch.data.in_blue, in_ch.data.in_green, in_ch.data.in_red};

  gb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_pix(pix), .restart(restart), .width_cfg(width_r), .height_cfg(height_r),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  gb3_merge u_merge (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .coef(coef_r), .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res(res)
  );

  assign out_ch.data.out_red       = res.red;
  assign out_ch.data.out_green     = res.green;
  assign out_ch.data.out_blue      = res.blue;
  assign out_ch.data.out_row       = res.row;
  assign out_ch.data.out_col       = res.col;
  assign out_ch.data.last_of_burst = res.last;

  // result column in range; results and jobs held while refused
  `GB_ASSERT_IMP(a_out_col_range, out_ch.valid, 32'(out_ch.data.out_col) < MAX_WIDTH, "col out of range")
  `GB_ASSERT_NEXT(a_stall_hold, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped under stall")
  `GB_ASSERT_NEXT(a_job_hold, job_valid && !job_ready, job_valid, "job dropped under stall")
endmodule
`default_nettype wire

>>> hw/rtl/gb3_lane.sv
// ---------------------------------------------------------------------------
// gb3_lane
// One color channel: nine taps weighted, two register stages, round, clip.
// ---------------------------------------------------------------------------
`default_nettype none
module gb3_lane (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [8:0][7:0]   taps,   // [4]=center, [1,3,5,7]=edge
  input  wire gb3_pkg::coef_t    coef,
  output logic [7:0]             pix_out
);
  import gb3_pkg::*;

  logic [25:0] p_center_r, p_edge_r, p_corner_r;
  logic [9:0]  esum, csum;
  logic [27:0] total;
  logic [11:0] q;
  logic [7:0]  pix_r;

  assign esum = 10'(taps[1]) + 10'(taps[3]) + 10'(taps[5]) + 10'(taps[7]);
  assign csum = 10'(taps[0]) + 10'(taps[2]) + 10'(taps[6]) + 10'(taps[8]);

  // stage 1: three products
  always_ff @(posedge clk) begin
    if (en) begin
      p_center_r <= 26'(coef.center * taps[4]);
      p_edge_r   <= 26'(coef.edge_w * esum);
      p_corner_r <= 26'(coef.corner * csum);
    end
  end

  // stage 2: sum, ceiling, saturate
  assign total = 28'(p_center_r) + 28'(p_edge_r) + 28'(p_corner_r) + 28'd65535;
  assign q = total[27:16];

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= (q > 12'd255) ? 8'hFF : q[7:0];
    end
  end

  assign pix_out = pix_r;
endmodule
`default_nettype wire

>>> hw/rtl/gb3_window.sv
// ---------------------------------------------------------------------------
// gb3_window
// Line stores, 3x3 window and burst sequencer: turns pixels into jobs.
// ---------------------------------------------------------------------------
`default_nettype none
module gb3_window #(
  parameter int unsigned MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire gb3_pkg::pix_t in_pix,
  input  wire logic          restart,
  input  wire logic [10:0]   width_cfg,
  input  wire logic [15:0]   height_cfg,
  output logic               job_valid,
  input  wire logic          job_ready,
  output gb3_pkg::job_t      job
);
  import gb3_pkg::*;
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

  // effective geometry
  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;
  always_comb begin
    if (width_cfg < 11'd3) w_eff = CW'(3);
    else if (32'(width_cfg) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_cfg);
    h_eff = (height_cfg < 16'd3) ? 16'd3 : height_cfg;
  end

  // stage A: line-store read
  pix_t mem_up [MAX_WIDTH];
  pix_t mem_mid [MAX_WIDTH];
  logic [CW-1:0] col_r;
  logic [15:0]   row_r;
  logic          a_vld_r;
  pix_t          a_pix_r, a_up_r, a_mid_r;
  logic [CW-1:0] a_col_r;
  logic [15:0]   a_row_r;
  logic          adv, acc;

  // burst hold for stage B
  logic          b_vld_r;
  pix_t [2:0][2:0] win_r;
  logic [15:0]   b_row_r;
  logic [CW-1:0] b_col_r;
  logic [3:0]    b_mask_r;
  logic [1:0]    b_idx;

  // burst sequencer signals
  logic [3:0] cur_mask, rest;
  logic [1:0] sel;

  // stage B frees up in the cycle its last job transfers
  logic          b_free;
  assign b_free = !b_vld_r || (job_ready && (rest == '0));
  assign adv = !a_vld_r || b_free;
  assign in_ready = adv;
  assign acc = in_valid && in_ready;

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (col_r + CW'(1) >= w_eff) begin
        col_r <= '0;
        row_r <= (row_r + 16'd1 >= h_eff) ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  logic [CW-1:0] c_now;
  logic [15:0]   r_now;
  assign c_now = (col_r >= w_eff) ? '0 : col_r;
  assign r_now = (row_r >= h_eff) ? 16'd0 : row_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      a_up_r  <= mem_up[c_now[AW-1:0]];
      a_mid_r <= mem_mid[c_now[AW-1:0]];
      a_pix_r <= in_pix;
      a_col_r <= c_now;
      a_row_r <= r_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= acc;
  end

  // stage B: window shift and line-store write
  pix_t [2:0] colv;
  logic [3:0] mask;
  logic is_last_row;
  assign is_last_row = (a_row_r == h_eff - 16'd1);
  always_comb begin
    colv[2] = a_pix_r;
    colv[1] = (a_row_r == 16'd0) ? a_pix_r : a_mid_r;
    colv[0] = (a_row_r == 16'd0) ? a_pix_r : a_up_r;
    mask = '0;
    if (a_row_r != 16'd0) begin
      mask[0] = (a_col_r != '0);
      mask[1] = (a_col_r == w_eff - CW'(1));
      mask[2] = is_last_row && (a_col_r != '0);
      mask[3] = is_last_row && (a_col_r == w_eff - CW'(1));
    end
  end

  logic take_b;
  assign take_b = a_vld_r && b_free;

  always_ff @(posedge clk) begin
    if (take_b) begin
      mem_up[a_col_r[AW-1:0]]  <= colv[1];
      mem_mid[a_col_r[AW-1:0]] <= a_pix_r;
      for (int i = 0; i < 3; i++) begin
        if (a_col_r == '0) begin
          win_r[i][0] <= colv[i];
          win_r[i][1] <= colv[i];
        end else begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[i][2] <= colv[i];
      end
      b_row_r  <= a_row_r;
      b_col_r  <= a_col_r;
    end
  end

  // burst sequencer: walks set bits of the mask
  always_comb begin
    cur_mask = b_mask_r;
    sel = 2'd0;
    if (cur_mask[0]) sel = 2'd0;
    else if (cur_mask[1]) sel = 2'd1;
    else if (cur_mask[2]) sel = 2'd2;
    else sel = 2'd3;
    rest = cur_mask & ~(4'b0001 << sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r  <= 1'b0;
      b_mask_r <= '0;
    end else if (take_b) begin
      b_vld_r  <= (mask != '0);
      b_mask_r <= mask;
    end else if (b_vld_r && job_ready) begin
      b_mask_r <= rest;
      b_vld_r  <= (rest != '0);
    end
  end
  assign b_idx = sel;

  // job payload from the held window
  always_comb begin
    job = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        job.tap[i][j] = win_r[(b_idx[1] && i == 0) ? 1 : ((b_idx[1] && i == 1) ? 2 : i)]
                             [(b_idx[0] && j == 0) ? 1 : ((b_idx[0] && j == 1) ? 2 : j)];
      end
    end
    job.row  = b_idx[1] ? b_row_r : b_row_r - 16'd1;
    job.col  = b_idx[0] ? 10'(b_col_r) : 10'(b_col_r - CW'(1));
    job.last = (rest == '0);
  end
  assign job_valid = b_vld_r;
endmodule
`default_nettype wire

>>> hw/rtl/gb3_merge.sv
// ---------------------------------------------------------------------------
// gb3_merge
// Three color lanes in parallel, merged with the position into one result.
// ---------------------------------------------------------------------------
`default_nettype none
module gb3_merge (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire gb3_pkg::job_t  job,
  input  wire gb3_pkg::coef_t coef,
  output logic                res_valid,
  input  wire logic           res_ready,
  output gb3_pkg::res_t       res
);
  import gb3_pkg::*;

  logic [1:0]  vld_r;
  logic [26:0] tag1_r, tag2_r;
  logic        en;
  logic [2:0][7:0] lane_out;
  logic [2:0][8:0][7:0] lane_taps;

  // pipeline moves unless the output is stalled and full
  assign en = !(vld_r[1] && !res_ready);
  assign job_ready = en;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        lane_taps[ch][k] = job.tap[k / 3][k % 3][8*ch +: 8];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    gb3_lane u_lane (
      .clk(clk), .en(en), .taps(lane_taps[ch]), .coef(coef), .pix_out(lane_out[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[0], job_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r <= {job.row, job.col, job.last};
      tag2_r <= tag1_r;
    end
  end

  // merge stage
  assign res_valid = vld_r[1];
  assign res.red   = lane_out[0];
  assign res.green = lane_out[1];
  assign res.blue  = lane_out[2];
  assign res.row   = tag2_r[26:11];
  assign res.col   = tag2_r[10:1];
  assign res.last  = tag2_r[0];
endmodule
`default_nettype wire
